// ===== hw/rtl/rc5dec_pkg.sv =====
package rc5dec_pkg;

    localparam int unsigned DurW    = 16;
    localparam int unsigned HalfW   = 15;
    localparam int unsigned CountW  = 5;
    localparam int unsigned SampleW = 13;
    localparam int unsigned CmdW    = 7;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned CfgIdxW = 2;

    // Stored half-bit count once position 25 has been reached.
    localparam logic [CountW-1:0] DoneCount = 5'd26;

    localparam logic [HalfW-1:0] HalfMinReset = 15'd622;
    localparam logic [HalfW-1:0] HalfMaxReset = 15'd1156;
    localparam logic [DurW-1:0]  EndGapReset  = 16'd20000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_HALF_MIN = 2'd0,
        CFG_HALF_MAX = 2'd1,
        CFG_END_GAP  = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        DUR_INVALID = 3'b001,
        DUR_HALF    = 3'b010,
        DUR_FULL    = 3'b100
    } t_dur_class;

    typedef struct packed {
        logic [DurW-1:0] duration;
        logic            frame_end;
    } t_in_word;

    typedef struct packed {
        logic            frame_valid;
        logic [CmdW-1:0] command;
        logic [AddrW-1:0] address;
        logic            toggle;
    } t_out_word;

    typedef struct packed {
        logic [CountW-1:0]  count;
        logic               is_space;
        logic [SampleW-1:0] bits;
        logic               error;
    } t_frame_state;

endpackage

// ===== hw/rtl/rc5dec_step.sv =====
module rc5dec_step (
    input  rc5dec_pkg::t_frame_state i_state,
    input  rc5dec_pkg::t_in_word     i_word,
    input  logic [14:0]              i_half_min,
    input  logic [14:0]              i_half_max,
    input  logic [15:0]              i_end_gap,
    output rc5dec_pkg::t_frame_state o_state_next,
    output rc5dec_pkg::t_out_word    o_result
);
    import rc5dec_pkg::*;

    logic [DurW-1:0]    full_min;
    logic [DurW-1:0]    full_max;
    t_dur_class         dur_class;
    logic [CountW-1:0]  count_add;
    t_frame_state       upd;
    logic               valid;
    logic [SampleW-1:0] inv;

    // Doubled bounds fit in 16 bits, so no overflow is possible.
    assign full_min = {i_half_min, 1'b0};
    assign full_max = {i_half_max, 1'b0};

    always_comb begin
        if (i_word.duration < {1'b0, i_half_min}) begin
            dur_class = DUR_INVALID;
        end else if (i_word.duration <= {1'b0, i_half_max}) begin
            dur_class = DUR_HALF;
        end else if (i_word.duration >= full_min && i_word.duration <= full_max) begin
            dur_class = DUR_FULL;
        end else begin
            dur_class = DUR_INVALID;
        end
    end

    always_comb begin
        upd = i_state;
        count_add = i_state.count;
        case (dur_class)
            DUR_HALF: count_add = i_state.count + 5'd1;
            DUR_FULL: count_add = i_state.count + 5'd2;
            default:  count_add = i_state.count;
        endcase
        if (!i_state.error && i_state.count < DoneCount) begin
            if (dur_class == DUR_INVALID) begin
                upd.error = 1'b1;
            end else begin
                upd.count = count_add;
                // Odd position: stored count is even and nonzero.
                if (count_add >= 5'd2 && !count_add[0]) begin
                    upd.bits = {i_state.bits[SampleW-2:0], ~i_state.is_space};
                end
            end
        end
        upd.is_space = ~i_state.is_space;
    end

    assign valid = !upd.error && upd.count >= DoneCount && i_word.duration >= i_end_gap;
    assign inv   = ~upd.bits;

    always_comb begin
        o_result = '0;
        o_result.frame_valid = valid;
        if (valid) begin
            o_result.command = {upd.bits[12], inv[5:0]};
            o_result.address = inv[10:6];
            o_result.toggle  = inv[11];
        end
    end

    // The last duration of a capture leaves the frame state cleared.
    assign o_state_next = i_word.frame_end ? t_frame_state'('0) : upd;

endmodule

// ===== hw/rtl/rc5dec_skid.sv =====
module rc5dec_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rc5dec_pkg::t_out_word i_word,
    output logic                  o_full,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rc5dec_pkg::t_out_word o_out_word
);
    import rc5dec_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_word r_out_word, n_out_word;
    t_out_word r_skid_word, n_skid_word;
    logic      slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (slot_free) begin
            n_out_valid  = r_skid_valid || i_push;
            n_out_word   = r_skid_valid ? r_skid_word : i_word;
            n_skid_valid = 1'b0;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_word  = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed while skid stage is full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_stall |=> r_out_valid && !r_skid_valid)
        else $error("skid word not moved to output");

endmodule

// ===== hw/rtl/rc5_ir_frame_decoder.sv =====
// RC5 infrared frame decoder. Input words carry the mark and space durations
// of one IR capture in microseconds, starting with a mark, and the last
// duration of the capture is flagged with frame_end. Each duration is classed
// as a half bit or a full bit against the half_bit_min and half_bit_max
// registers, and the level is sampled at every odd half-bit position until
// position 25 is reached. On the flagged word the block delivers one output
// word holding the extended command, the address, the toggle bit and a valid
// flag; valid also needs the final duration to be at least end_gap_min. Words
// that are not flagged produce no output. One input word is taken in every
// clock cycle while o_in_stall is low: the frame state (half-bit count,
// mark/space parity, sample register and sticky error) is updated per accepted
// word, and this feedback loop sets the rate. A result reaches o_out_word on
// the cycle after its input word is accepted when the output register is free;
// otherwise it waits in a one-word skid stage behind the output register until
// the output word ahead of it is taken. This lets input continue while a
// result waits; input stalls only when both are full. Configuration registers
// are written with i_cfg_we, i_cfg_index and i_cfg_data; the user must write
// them only while the block is idle (unenforced); unknown indexes are ignored.
module rc5_ir_frame_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rc5dec_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rc5dec_pkg::t_out_word o_out_word
);
    import rc5dec_pkg::*;

    logic [HalfW-1:0] r_half_min;
    logic [HalfW-1:0] r_half_max;
    logic [DurW-1:0]  r_end_gap;
    t_frame_state     r_state;
    t_frame_state     n_state;
    t_out_word        result;
    logic             in_fire;
    logic             skid_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_min <= HalfMinReset;
            r_half_max <= HalfMaxReset;
            r_end_gap  <= EndGapReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HALF_MIN: r_half_min <= i_cfg_data[HalfW-1:0];
                CFG_HALF_MAX: r_half_max <= i_cfg_data[HalfW-1:0];
                CFG_END_GAP:  r_end_gap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = skid_full;
    assign in_fire    = i_in_valid && !skid_full;

    // Classing, sampling and result forming for one duration.
    rc5dec_step u_step (
        .i_state      (r_state),
        .i_word       (i_in_word),
        .i_half_min   (r_half_min),
        .i_half_max   (r_half_max),
        .i_end_gap    (r_end_gap),
        .o_state_next (n_state),
        .o_result     (result)
    );

    // The frame state advances once for every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register plus skid stage.
    rc5dec_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_fire && i_in_word.frame_end),
        .i_word      (result),
        .o_full      (skid_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= 5'd27)
        else $error("half-bit count beyond its reachable range");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_word.frame_end |=> r_state == '0)
        else $error("frame state not cleared after last duration");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_word.frame_end |=> o_out_valid)
        else $error("last duration did not produce an output word");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.frame_valid |->
            o_out_word.command == '0 && o_out_word.address == '0 && !o_out_word.toggle)
        else $error("invalid frame carries nonzero fields");

endmodule

// ===== sim/rc5_ir_frame_decoder_tb.sv =====
`timescale 1ns / 100ps

// Self-checking testbench for the RC5 infrared frame decoder.
// A stimulus process fills a queue of input words: durations that form real
// RC5 captures with random content, damaged captures and plain noise. A
// driver feeds that queue to the block over the valid/stall handshake, and a
// monitor predicts each result from every accepted input word and checks
// every accepted output word against the oldest prediction.
module rc5_ir_frame_decoder_tb;
    import rc5dec_pkg::*;

    // The index that no register answers to; writes to it must be ignored.
    localparam logic [CfgIdxW-1:0] CfgIndexUnused = 2'd3;
    // Quiet cycles needed before the block counts as idle.
    localparam int SettleCycles = 4;
    // Cycles without any accepted word before the run is declared hung.
    localparam int StuckLimit = 3000;
    // Length of the one long output hold-off that backs the block up.
    localparam int HoldCycles = 150;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [DurW-1:0]    i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;

    // Words waiting to be driven, and frames the block still owes us.
    t_in_word  durations_to_send[$];
    t_out_word frames_due[$];
    // Scratch buffer where one capture is built before it is queued.
    t_in_word  capture_buf[$];

    // Our own copy of the configuration registers.
    logic [HalfW-1:0] cfg_half_min;
    logic [HalfW-1:0] cfg_half_max;
    logic [DurW-1:0]  cfg_gap_min;

    // Our own copy of the frame state.
    logic [CountW-1:0]  half_count;
    logic               at_space;
    logic [SampleW-1:0] level_bits;
    logic               sticky_err;

    // Handshake bookkeeping. All of these are written at the rising edge by
    // the monitor and read at the falling edge, so there is no race.
    logic in_taken       = 1'b0;
    int   settled_cycles = 0;
    int   stuck_cycles   = 0;
    int   err_count      = 0;

    // Idle rates in percent, and the long hold-off request.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_armed    = 1'b0;
    logic hold_used     = 1'b0;
    int   hold_left     = 0;

    rc5_ir_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Class one duration against the half-bit window and its doubled
    // window. The doubled bounds are held one bit wider so they never wrap.
    function automatic t_dur_class class_of_duration(input logic [DurW-1:0] t);
        logic [DurW:0] full_lo;
        logic [DurW:0] full_hi;
        full_lo = {1'b0, cfg_half_min, 1'b0};
        full_hi = {1'b0, cfg_half_max, 1'b0};
        if (t < cfg_half_min)
            return DUR_INVALID;
        if (t <= cfg_half_max)
            return DUR_HALF;
        if ({1'b0, t} >= full_lo && {1'b0, t} <= full_hi)
            return DUR_FULL;
        return DUR_INVALID;
    endfunction

    task automatic clear_frame();
        half_count = '0;
        at_space   = 1'b0;
        level_bits = '0;
        sticky_err = 1'b0;
    endtask

    // Advance the frame state by one accepted duration. On the word that
    // closes a capture, the decoded frame is queued and the state cleared.
    task automatic decode_duration(input t_in_word w);
        t_dur_class         cls;
        t_out_word          frame;
        logic [SampleW-1:0] s;
        logic               is_mark;
        is_mark = !at_space;
        // Once an error is flagged or position 25 is passed, durations are
        // no longer classed; only the mark/space parity keeps flipping.
        if (!sticky_err && half_count < DoneCount) begin
            cls = class_of_duration(w.duration);
            if (cls == DUR_INVALID) begin
                sticky_err = 1'b1;
            end else begin
                half_count = half_count + ((cls == DUR_FULL) ? 5'd2 : 5'd1);
                // An even stored count means the position just became odd.
                if (half_count >= 5'd2 && !half_count[0])
                    level_bits = {level_bits[SampleW-2:0], is_mark};
            end
        end
        at_space = !at_space;
        if (w.frame_end) begin
            frame = '0;
            // A frame that fails any check reports all of its fields as zero.
            if (!sticky_err && half_count >= DoneCount && w.duration >= cfg_gap_min) begin
                s = ~level_bits;
                frame.frame_valid = 1'b1;
                frame.command     = {~s[12], s[5:0]};
                frame.address     = s[10:6];
                frame.toggle      = s[11];
            end
            frames_due.push_back(frame);
            clear_frame();
        end
    endtask

    function automatic void check_field(input string name, input logic [6:0] want,
                                        input logic [6:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: tracks register writes, predicts from every accepted input
    // word and checks every accepted output word. It also keeps the idle
    // count that the stimulus waits on, and the hang watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        logic      out_taken;
        if (!i_rst_n) begin
            cfg_half_min = HalfMinReset;
            cfg_half_max = HalfMaxReset;
            cfg_gap_min  = EndGapReset;
            clear_frame();
            in_taken       = 1'b0;
            settled_cycles = 0;
            stuck_cycles   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HALF_MIN: cfg_half_min = i_cfg_data[HalfW-1:0];
                    CFG_HALF_MAX: cfg_half_max = i_cfg_data[HalfW-1:0];
                    CFG_END_GAP:  cfg_gap_min  = i_cfg_data;
                    default: ;
                endcase
            end

            in_taken  = i_in_valid && !o_in_stall;
            out_taken = o_out_valid && !i_out_stall;

            if (in_taken)
                decode_duration(i_in_word);

            if (out_taken) begin
                if (frames_due.size() == 0) begin
                    $error("output word with no frame pending: %h", o_out_word);
                    err_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_valid", 7'(want.frame_valid), 7'(o_out_word.frame_valid));
                    check_field("command", want.command, o_out_word.command);
                    check_field("address", 7'(want.address), 7'(o_out_word.address));
                    check_field("toggle", 7'(want.toggle), 7'(o_out_word.toggle));
                end
            end

            // The block is idle once nothing is queued or offered and every
            // predicted frame has come out.
            if (durations_to_send.size() == 0 && !i_in_valid && frames_due.size() == 0)
                settled_cycles++;
            else
                settled_cycles = 0;

            if (in_taken || out_taken)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= StuckLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the next queued word when the slot is free. A word
    // that is offered stays put until it is taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (durations_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= durations_to_send.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request. The
    // hold-off is counted here so that it does not depend on the sender.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_armed && !hold_used) begin
            hold_left = HoldCycles;
            hold_used = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. These run in the stimulus process at falling edges.
    // ------------------------------------------------------------------

    // Drives one register write for a single cycle. The caller drops the
    // write enable after its last write, so back-to-back writes never touch
    // the enable twice at the same edge.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic wait_settled();
        @(negedge i_clk);
        while (settled_cycles < SettleCycles)
            @(negedge i_clk);
    endtask

    task automatic queue_word(input logic [DurW-1:0] d, input logic last);
        t_in_word w;
        w.duration  = d;
        w.frame_end = last;
        durations_to_send.push_back(w);
    endtask

    // A duration of one or two half bits under the current registers,
    // either anywhere in the window or right on one of its edges.
    function automatic logic [DurW-1:0] pick_len(input int halves, input logic edges);
        int lo;
        int hi;
        if (halves == 1) begin
            lo = int'(cfg_half_min);
            hi = int'(cfg_half_max);
        end else begin
            lo = (2 * cfg_half_min > cfg_half_max + 1) ? 2 * cfg_half_min : cfg_half_max + 1;
            hi = (2 * cfg_half_max > 65535) ? 65535 : 2 * cfg_half_max;
        end
        if (lo > 65535)
            lo = 65535;
        if (edges)
            return ($urandom_range(1) != 0) ? lo[DurW-1:0] : hi[DurW-1:0];
        return DurW'($urandom_range(hi, lo));
    endfunction

    // Build one capture into capture_buf: start bit 1, then the second start
    // bit, toggle, address and command from 'bits', most significant first.
    // A one is sent space then mark. The space before the first mark is not
    // captured, and a trailing space merges into the final gap.
    task automatic build_capture(input logic [SampleW-1:0] bits, input logic edges,
                                 input logic [DurW-1:0] gap);
        logic        levels[$];
        logic [13:0] all_bits;
        int          run;
        t_in_word    w;
        all_bits = {1'b1, bits};
        capture_buf.delete();
        for (int k = 13; k >= 0; k--) begin
            levels.push_back(!all_bits[k]);
            levels.push_back(all_bits[k]);
        end
        levels.delete(0);
        if (levels[levels.size() - 1] == 1'b0)
            levels.delete(levels.size() - 1);
        run = 1;
        for (int i = 1; i <= levels.size(); i++) begin
            if (i < levels.size() && levels[i] == levels[i - 1]) begin
                run++;
            end else begin
                w.duration  = pick_len(run, edges);
                w.frame_end = 1'b0;
                capture_buf.push_back(w);
                run = 1;
            end
        end
        w.duration  = gap;
        w.frame_end = 1'b1;
        capture_buf.push_back(w);
    endtask

    // Slip extra half bits in before the final gap, past position 25.
    task automatic pad_past_end(input int n);
        t_in_word w;
        w.frame_end = 1'b0;
        repeat (n) begin
            w.duration = pick_len(1, 1'b0);
            capture_buf.insert(capture_buf.size() - 1, w);
        end
    endtask

    // Random gap: mostly long enough to close a valid frame.
    function automatic logic [DurW-1:0] pick_gap();
        if ($urandom_range(99) < 80)
            return DurW'($urandom_range(65535, cfg_gap_min));
        return DurW'($urandom_range(65535));
    endfunction

    // One random sequence: a clean capture, a damaged one, or noise.
    // Returns the number of words queued.
    task automatic queue_sequence(output int n_words);
        int       pick;
        int       cut;
        int       idx;
        t_in_word w;
        pick = $urandom_range(99);
        if (pick < 85) begin
            build_capture(SampleW'($urandom_range(13'h1FFF)), ($urandom_range(9) == 0),
                          pick_gap());
            if (pick >= 70) begin
                case ($urandom_range(3))
                    0: begin
                        // One duration goes out of any window, or anywhere.
                        idx = $urandom_range(capture_buf.size() - 1);
                        w = capture_buf[idx];
                        w.duration = DurW'($urandom_range(65535));
                        capture_buf[idx] = w;
                    end
                    1: begin
                        // The capture ends early.
                        cut = $urandom_range(capture_buf.size() - 1);
                        while (capture_buf.size() > cut + 1)
                            capture_buf.delete(capture_buf.size() - 1);
                        w = capture_buf[cut];
                        w.frame_end = 1'b1;
                        capture_buf[cut] = w;
                    end
                    2: pad_past_end($urandom_range(4, 1));
                    default: begin
                        // No end flag: the next sequence runs on in this frame.
                        w = capture_buf[capture_buf.size() - 1];
                        w.frame_end = 1'b0;
                        capture_buf[capture_buf.size() - 1] = w;
                    end
                endcase
            end
        end else begin
            capture_buf.delete();
            cut = $urandom_range(5, 1);
            for (int i = 0; i < cut; i++) begin
                w.duration  = DurW'($urandom_range(65535));
                w.frame_end = (i == cut - 1) && ($urandom_range(3) != 0);
                capture_buf.push_back(w);
            end
        end
        foreach (capture_buf[i])
            durations_to_send.push_back(capture_buf[i]);
        n_words = capture_buf.size();
    endtask

    // Set all registers, poke the unused index, then run random sequences
    // until about 'target' words are queued, and wait for the block to idle.
    task automatic run_segment(input logic [HalfW-1:0] half_min, input logic [HalfW-1:0] half_max,
                               input logic [DurW-1:0] gap_min, input int target);
        int   queued;
        int   n_words;
        logic top_bit;
        top_bit = 1'($urandom_range(1));
        write_reg(CFG_HALF_MIN, {top_bit, half_min});
        top_bit = 1'($urandom_range(1));
        write_reg(CFG_HALF_MAX, {top_bit, half_max});
        write_reg(CFG_END_GAP, gap_min);
        write_reg(CfgIndexUnused, DurW'($urandom_range(65535)));
        i_cfg_we <= 1'b0;
        queued = 0;
        while (queued < target) begin
            queue_sequence(n_words);
            queued += n_words;
        end
        wait_settled();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles now and then, receiver most of the time.
        send_idle_pct = 17;
        recv_idle_pct = 84;

        // Directed words under the reset register values. A zero duration
        // and the longest duration each close a frame on their own; a
        // duration in the half-bit window followed by an invalid one shows
        // that the error is sticky up to the end flag.
        queue_word(16'd0, 1'b1);
        queue_word(16'hFFFF, 1'b1);
        queue_word({1'b0, HalfMinReset}, 1'b0);
        queue_word(16'd0, 1'b1);
        // All-ones frame on the window edges, with the longest gap.
        build_capture(13'h1FFF, 1'b1, 16'hFFFF);
        foreach (capture_buf[i])
            durations_to_send.push_back(capture_buf[i]);
        // Alternating bits give full-bit durations; the gap sits exactly on
        // the threshold.
        build_capture(13'h0AAA, 1'b1, EndGapReset);
        foreach (capture_buf[i])
            durations_to_send.push_back(capture_buf[i]);
        // Extra durations after position 25 and a gap one short of the
        // threshold.
        build_capture(13'h1555, 1'b1, EndGapReset - 16'd1);
        pad_past_end(2);
        foreach (capture_buf[i])
            durations_to_send.push_back(capture_buf[i]);
        wait_settled();

        run_segment(15'd500, 15'd1300, 16'd5000, 130);
        // Widest window: zero is a half bit and only the longest gap ends
        // a valid frame.
        run_segment(15'd0, 15'h7FFF, 16'hFFFF, 70);

        // Now the sender is the slow side.
        send_idle_pct = 84;
        recv_idle_pct = 17;
        // Narrowest window at the top of the range, and no gap requirement.
        run_segment(15'h7FFF, 15'h7FFF, 16'd0, 80);
        // Bounds out of order: nothing classes as a half or a full bit.
        run_segment(15'd1000, 15'd400, 16'd20000, 30);
        run_segment(15'd700, 15'd1000, 16'd30000, 60);

        // Full rate both ways, with one long output hold-off so the block
        // fills up and has to stall its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed = 1'b1;
        run_segment(HalfMinReset, HalfMaxReset, EndGapReset, 150);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
